### hdl/pacd_pkg.sv
// ----------------------------------------------------------------------------
// pacd_pkg: shared types and constants for the pll audio clock divider
// Field widths, register indexes, status codes and the item records that
// travel beside the divider chains.
// ----------------------------------------------------------------------------
`default_nettype none

package pacd_pkg;

    // configuration
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;
    localparam int FB_W       = 7;
    localparam int IP_W       = 5;
    localparam int OP_W       = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_FEEDBACK   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INPUT_DIV  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUTPUT_DIV = 2'd2;

    // item fields
    localparam int RATE_W   = 20;
    localparam int CODE_W   = 7;
    localparam int PLL_W    = 29;
    localparam int DIVO_W   = 7;
    localparam int ARATE_W  = 21;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_AUDIO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_RATE = 2'd2;

    // stream widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;
    localparam int USER_W     = 2;

    // arithmetic
    localparam int             XTAL_W    = 22;
    localparam logic [XTAL_W-1:0] XTAL_HZ = 22'd3686400;
    localparam int             FBP_W     = FB_W + 1;
    localparam int             PROD_W    = XTAL_W + FBP_W;
    localparam int             AUD_SHIFT = 8;
    localparam int             AUD_W     = PLL_W - AUD_SHIFT;
    localparam int             DIV_MAX   = 128;

    // first chain: crystal product over the input divider
    localparam int NUM1_W = PLL_W;
    localparam int DEN1_W = IP_W + 1;
    // second chain: audio numerator over rate or divider
    localparam int NUM2_W = AUD_W + 1;
    localparam int DEN2_W = RATE_W;

    typedef struct packed {
        logic [OP_W-1:0]   op_sel;
        logic              kind;
        logic              audio;
        logic [RATE_W-1:0] rate;
        logic [CODE_W-1:0] code;
    } div1_side_t;

    typedef struct packed {
        logic [PLL_W-1:0]    pll;
        logic                kind;
        logic [STATUS_W-1:0] status;
    } div2_side_t;

    // output divider 1, 4, 2, 8 as a right shift
    function automatic logic [1:0] out_div_shift(input logic [OP_W-1:0] sel);
        logic [1:0] sh;
        case (sel)
            2'd0:    sh = 2'd0;
            2'd1:    sh = 2'd2;
            2'd2:    sh = 2'd1;
            2'd3:    sh = 2'd3;
            default: sh = 2'd0;
        endcase
        return sh;
    endfunction

endpackage

`default_nettype wire

### hdl/pacd_div_cell.sv
// ----------------------------------------------------------------------------
// pacd_div_cell: one restoring division step
// Shifts one numerator bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit in at the bottom.
// ----------------------------------------------------------------------------
`default_nettype none

module pacd_div_cell #(
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 8,
    parameter int SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [DEN_W-1:0]  in_rem,
    input  wire logic [NUM_W-1:0]  in_numq,
    input  wire logic [DEN_W-1:0]  in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [DEN_W-1:0]       out_rem,
    output logic [NUM_W-1:0]       out_numq,
    output logic [DEN_W-1:0]       out_den,
    output logic [SIDE_W-1:0]      out_side
);

    logic              valid_reg;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  numq_reg, numq_next;
    logic [DEN_W-1:0]  den_reg;
    logic [SIDE_W-1:0] side_reg;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    always_comb begin
        trial     = {in_rem, in_numq[NUM_W-1]};
        diff      = trial - {1'b0, in_den};
        take      = (trial >= {1'b0, in_den});
        rem_next  = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        numq_next = {in_numq[NUM_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            numq_reg <= numq_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_numq  = numq_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

### hdl/pacd_div_chain.sv
// ----------------------------------------------------------------------------
// pacd_div_chain: pipelined unsigned divider
// A row of NUM_W division cells, one quotient bit per cell, carrying the
// divisor and the item's side record along with the partial result.
// ----------------------------------------------------------------------------
`default_nettype none

module pacd_div_chain #(
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 8,
    parameter int SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  in_num,
    input  wire logic [DEN_W-1:0]  in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [NUM_W-1:0]       out_quot,
    output logic [SIDE_W-1:0]      out_side
);

    logic              valid_w [0:NUM_W];
    logic [DEN_W-1:0]  rem_w   [0:NUM_W-1];
    logic [NUM_W-1:0]  numq_w  [0:NUM_W];
    logic [DEN_W-1:0]  den_w   [0:NUM_W];
    logic [SIDE_W-1:0] side_w  [0:NUM_W];

    assign valid_w[0] = in_valid;
    assign rem_w[0]   = '0;
    assign numq_w[0]  = in_num;
    assign den_w[0]   = in_den;
    assign side_w[0]  = in_side;

    for (genvar i = 0; i < NUM_W; i++) begin : g_cell
        if (i == NUM_W - 1) begin : g_last
            // final remainder is not needed downstream
            pacd_div_cell #(
                .NUM_W  (NUM_W),
                .DEN_W  (DEN_W),
                .SIDE_W (SIDE_W)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (valid_w[i]),
                .in_rem    (rem_w[i]),
                .in_numq   (numq_w[i]),
                .in_den    (den_w[i]),
                .in_side   (side_w[i]),
                .out_valid (valid_w[i+1]),
                .out_rem   (),
                .out_numq  (numq_w[i+1]),
                .out_den   (den_w[i+1]),
                .out_side  (side_w[i+1])
            );
        end else begin : g_mid
            pacd_div_cell #(
                .NUM_W  (NUM_W),
                .DEN_W  (DEN_W),
                .SIDE_W (SIDE_W)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (valid_w[i]),
                .in_rem    (rem_w[i]),
                .in_numq   (numq_w[i]),
                .in_den    (den_w[i]),
                .in_side   (side_w[i]),
                .out_valid (valid_w[i+1]),
                .out_rem   (rem_w[i+1]),
                .out_numq  (numq_w[i+1]),
                .out_den   (den_w[i+1]),
                .out_side  (side_w[i+1])
            );
        end
    end

    assign out_valid = valid_w[NUM_W];
    assign out_quot  = numq_w[NUM_W];
    assign out_side  = side_w[NUM_W];

endmodule

`default_nettype wire

### hdl/pll_audio_clock_divider.sv
// ----------------------------------------------------------------------------
// pll_audio_clock_divider: pll frequency and audio divider calculator
// Derives the pll frequency from the configured divider codes and, per item,
// either the audio divider code for a requested rate or the audio rate for a
// given divider code.
// ----------------------------------------------------------------------------
// The block takes one item per clock and returns one result item for each:
// a register stage forms the crystal product, a 29-cell chain divides it by
// the pll input divider, a register stage applies the output divider and
// sets up the audio division, a 22-cell chain performs that division, and
// the output stage clamps and registers the result. The whole pipeline moves
// together; while the output item is held by the sink, nothing advances and
// s_axis_tready is low. The three pll registers are taken by each item at
// acceptance, so they may be rewritten whenever no item is in flight.
`default_nettype none

module pll_audio_clock_divider (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration
    input  wire logic                               cfg_wr_en,
    input  wire logic [pacd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [pacd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // request items
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // requested_rate, divider_in
    input  wire logic [pacd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // kind, is_audio_block
    input  wire logic [pacd_pkg::USER_W-1:0]        s_axis_tuser,
    // result items
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // pll_hz, divider_out, audio_rate_hz
    output logic [pacd_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // status
    output logic [pacd_pkg::USER_W-1:0]             m_axis_tuser
);

    import pacd_pkg::*;

    localparam int PLL_LSB   = 0;
    localparam int DIVO_LSB  = PLL_LSB + PLL_W;
    localparam int ARATE_LSB = DIVO_LSB + DIVO_W;
    localparam int OUT_USED  = ARATE_LSB + ARATE_W;

    // ---------------- configuration registers
    logic [FB_W-1:0] feedback_reg;
    logic [IP_W-1:0] input_div_reg;
    logic [OP_W-1:0] output_div_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            feedback_reg   <= '0;
            input_div_reg  <= '0;
            output_div_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_FEEDBACK:   feedback_reg   <= cfg_wdata[FB_W-1:0];
                CFG_INPUT_DIV:  input_div_reg  <= cfg_wdata[IP_W-1:0];
                CFG_OUTPUT_DIV: output_div_reg <= cfg_wdata[OP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline enable
    logic m_valid_reg;
    logic en;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- stage 0: crystal product and input divider
    logic                s0_valid_reg;
    logic [NUM1_W-1:0]   s0_num_reg, s0_num_next;
    logic [DEN1_W-1:0]   s0_den_reg, s0_den_next;
    div1_side_t          s0_side_reg, s0_side_next;
    logic [FBP_W-1:0]    fb_plus;
    logic [PROD_W-1:0]   prod;

    always_comb begin
        fb_plus             = {1'b0, feedback_reg} + FBP_W'(2);
        prod                = PROD_W'(XTAL_HZ) * PROD_W'(fb_plus);
        s0_num_next         = prod[NUM1_W-1:0];
        s0_den_next         = {1'b0, input_div_reg} + DEN1_W'(2);
        s0_side_next.op_sel = output_div_reg;
        s0_side_next.kind   = s_axis_tuser[0];
        s0_side_next.audio  = s_axis_tuser[1];
        s0_side_next.rate   = s_axis_tdata[RATE_W-1:0];
        s0_side_next.code   = s_axis_tdata[RATE_W +: CODE_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_num_reg  <= s0_num_next;
            s0_den_reg  <= s0_den_next;
            s0_side_reg <= s0_side_next;
        end
    end

    // ---------------- first divider chain
    logic              d1_valid;
    logic [NUM1_W-1:0] d1_quot;
    div1_side_t        d1_side;

    pacd_div_chain #(
        .NUM_W  (NUM1_W),
        .DEN_W  (DEN1_W),
        .SIDE_W ($bits(div1_side_t))
    ) u_div1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .in_num    (s0_num_reg),
        .in_den    (s0_den_reg),
        .in_side   (s0_side_reg),
        .out_valid (d1_valid),
        .out_quot  (d1_quot),
        .out_side  (d1_side)
    );

    // ---------------- stage b: output divider and audio operands
    logic              sb_valid_reg;
    logic [NUM2_W-1:0] sb_num_reg, sb_num_next;
    logic [DEN2_W-1:0] sb_den_reg, sb_den_next;
    div2_side_t        sb_side_reg, sb_side_next;
    logic [PLL_W-1:0]  pll;
    logic [AUD_W-1:0]  aud;

    always_comb begin
        pll = d1_quot >> out_div_shift(d1_side.op_sel);
        aud = pll[PLL_W-1:AUD_SHIFT];
        if (d1_side.kind) begin
            sb_num_next = {1'b0, aud};
            sb_den_next = DEN2_W'(d1_side.code) + DEN2_W'(1);
        end else begin
            // round to nearest by adding half the rate
            sb_num_next = {1'b0, aud} + NUM2_W'(d1_side.rate[RATE_W-1:1]);
            sb_den_next = d1_side.rate;
        end
        sb_side_next.pll  = pll;
        sb_side_next.kind = d1_side.kind;
        if (!d1_side.audio) begin
            sb_side_next.status = STATUS_NOT_AUDIO;
        end else if (!d1_side.kind && d1_side.rate == '0) begin
            sb_side_next.status = STATUS_ZERO_RATE;
        end else begin
            sb_side_next.status = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sb_valid_reg <= 1'b0;
        end else if (en) begin
            sb_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_num_reg  <= sb_num_next;
            sb_den_reg  <= sb_den_next;
            sb_side_reg <= sb_side_next;
        end
    end

    // ---------------- second divider chain
    logic              d2_valid;
    logic [NUM2_W-1:0] d2_quot;
    div2_side_t        d2_side;

    pacd_div_chain #(
        .NUM_W  (NUM2_W),
        .DEN_W  (DEN2_W),
        .SIDE_W ($bits(div2_side_t))
    ) u_div2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sb_valid_reg),
        .in_num    (sb_num_reg),
        .in_den    (sb_den_reg),
        .in_side   (sb_side_reg),
        .out_valid (d2_valid),
        .out_quot  (d2_quot),
        .out_side  (d2_side)
    );

    // ---------------- output stage: clamp and select
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [USER_W-1:0]     m_user_reg, m_user_next;
    logic [DIVO_W-1:0]     div_code;
    logic [DIVO_W-1:0]     divo;
    logic [ARATE_W-1:0]    arate;
    logic [NUM2_W-1:0]     q_minus1;

    always_comb begin
        q_minus1 = d2_quot - NUM2_W'(1);
        // clamp the divider to 1..128, then store it minus one
        if (d2_quot == '0) begin
            div_code = '0;
        end else if (d2_quot > NUM2_W'(DIV_MAX)) begin
            div_code = DIVO_W'(DIV_MAX - 1);
        end else begin
            div_code = q_minus1[DIVO_W-1:0];
        end
        divo  = '0;
        arate = '0;
        if (d2_side.status == STATUS_OK) begin
            if (d2_side.kind) begin
                arate = d2_quot[ARATE_W-1:0];
            end else begin
                divo = div_code;
            end
        end
        m_data_next = {{(OUT_DATA_W - OUT_USED){1'b0}}, arate, divo, d2_side.pll};
        m_user_next = d2_side.status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // ---------------- assertions
    // an error status carries no divider and no rate
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != STATUS_OK)
            |-> (m_axis_tdata[OUT_USED-1:DIVO_LSB] == '0))
        else $error("error status with nonzero divider or rate");

    // only one of divider and rate is ever reported
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid
            |-> (m_axis_tdata[DIVO_LSB +: DIVO_W] == '0
                 || m_axis_tdata[ARATE_LSB +: ARATE_W] == '0))
        else $error("divider and rate both reported");

    // an accepted item enters the first stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> s0_valid_reg)
        else $error("accepted item lost at pipeline entry");

    // the pipeline holds still while the result is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(s0_valid_reg) && $stable(sb_valid_reg)))
        else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for pll_audio_clock_divider
// Runs a short table of hand-picked requests after reset, then phases of
// random requests under different pll settings, the extremes among them.
// Every accepted request gets an expected result, from the table or predicted
// in the bench, and each result item is compared field by field with the
// oldest one. Both stream sides idle and stall at random, but in the quiet phase.
// ----------------------------------------------------------------------------
module tb;
    import pacd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int N_PHASES     = 10;
    localparam int PHASE_ITEMS  = 193;
    localparam int QUIET_PHASE  = 5;
    localparam int TAIL_CYCLES  = 80;
    localparam int IDLE_PCT     = 12;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    localparam logic KIND_DIV_FROM_RATE = 1'b0;
    localparam logic KIND_RATE_FROM_DIV = 1'b1;

    localparam longint unsigned CRYSTAL_HZ = 3686400;
    localparam longint unsigned AUD_SCALE  = 256;
    localparam longint unsigned DIV_TOP    = 128;

    localparam logic [PLL_W-1:0] PLL_RESET_HZ = 29'd3686400;

    // result tdata offsets
    localparam int DIVO_LSB  = PLL_W;
    localparam int ARATE_LSB = PLL_W + DIVO_W;

    typedef struct packed {
        logic [PLL_W-1:0]    pll;
        logic [DIVO_W-1:0]   divo;
        logic [ARATE_W-1:0]  arate;
        logic [STATUS_W-1:0] status;
    } clk_result_t;

    typedef struct packed {
        logic              kind;
        logic              audio;
        logic [RATE_W-1:0] rate;
        logic [CODE_W-1:0] code;
        logic              typed;
        clk_result_t       res;
    } req_row_t;

    localparam clk_result_t NO_RES = '0;

    // hand-picked requests under reset settings: pll 3686400, pll/256 = 14400
    localparam int N_ROWS = 18;
    localparam req_row_t DIR_ROWS [N_ROWS] = '{
        '{KIND_DIV_FROM_RATE, 1'b0, 20'd48000,   7'd0,   1'b1,
          '{PLL_RESET_HZ, 7'd0, 21'd0, STATUS_NOT_AUDIO}},
        '{KIND_RATE_FROM_DIV, 1'b0, 20'd0,       7'd127, 1'b1,
          '{PLL_RESET_HZ, 7'd0, 21'd0, STATUS_NOT_AUDIO}},
        // not-audio wins over a zero rate
        '{KIND_DIV_FROM_RATE, 1'b0, 20'd0,       7'd0,   1'b1,
          '{PLL_RESET_HZ, 7'd0, 21'd0, STATUS_NOT_AUDIO}},
        '{KIND_DIV_FROM_RATE, 1'b1, 20'd0,       7'd0,   1'b1,
          '{PLL_RESET_HZ, 7'd0, 21'd0, STATUS_ZERO_RATE}},
        '{KIND_DIV_FROM_RATE, 1'b1, 20'd1,       7'd0,   1'b1,
          '{PLL_RESET_HZ, 7'd127, 21'd0, STATUS_OK}},
        '{KIND_DIV_FROM_RATE, 1'b1, 20'hFFFFF,   7'h7F,  1'b1,
          '{PLL_RESET_HZ, 7'd0, 21'd0, STATUS_OK}},
        '{KIND_DIV_FROM_RATE, 1'b1, 20'd14400,   7'd0,   1'b1,
          '{PLL_RESET_HZ, 7'd0, 21'd0, STATUS_OK}},
        '{KIND_DIV_FROM_RATE, 1'b1, 20'd112,     7'd0,   1'b0, NO_RES},
        '{KIND_DIV_FROM_RATE, 1'b1, 20'd113,     7'd0,   1'b0, NO_RES},
        '{KIND_DIV_FROM_RATE, 1'b1, 20'd9600,    7'd0,   1'b0, NO_RES},
        '{KIND_DIV_FROM_RATE, 1'b1, 20'd28800,   7'd0,   1'b0, NO_RES},
        '{KIND_DIV_FROM_RATE, 1'b1, 20'd28799,   7'd0,   1'b0, NO_RES},
        '{KIND_RATE_FROM_DIV, 1'b1, 20'd0,       7'd0,   1'b1,
          '{PLL_RESET_HZ, 7'd0, 21'd14400, STATUS_OK}},
        '{KIND_RATE_FROM_DIV, 1'b1, 20'hFFFFF,   7'd127, 1'b1,
          '{PLL_RESET_HZ, 7'd0, 21'd112, STATUS_OK}},
        // zero rate is not flagged when converting a divider
        '{KIND_RATE_FROM_DIV, 1'b1, 20'd0,       7'd63,  1'b0, NO_RES},
        '{KIND_RATE_FROM_DIV, 1'b1, 20'd44100,   7'd1,   1'b0, NO_RES},
        '{KIND_DIV_FROM_RATE, 1'b1, 20'd7200,    7'd0,   1'b0, NO_RES},
        '{KIND_DIV_FROM_RATE, 1'b1, 20'd44100,   7'd0,   1'b0, NO_RES}
    };

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [USER_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [USER_W-1:0]     m_axis_tuser;

    // bench copy of the pll registers
    logic [FB_W-1:0] fb_q = '0;
    logic [IP_W-1:0] ip_q = '0;
    logic [OP_W-1:0] op_q = '0;

    clk_result_t pending_results [$];
    logic        cur_typed = 1'b0;
    clk_result_t cur_res   = '0;
    logic        idle_on   = 1'b1;
    int          err_cnt   = 0;
    int          cycle_cnt = 0;

    pll_audio_clock_divider DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 aclk = ~aclk;

    function automatic longint unsigned out_div_of(input logic [OP_W-1:0] sel);
        case (sel)
            2'd0:    return 1;
            2'd1:    return 4;
            2'd2:    return 2;
            default: return 8;
        endcase
    endfunction

    function automatic longint unsigned pll_hz_of(input logic [FB_W-1:0] fb,
                                                  input logic [IP_W-1:0] ip,
                                                  input logic [OP_W-1:0] op);
        longint unsigned fbp;
        longint unsigned ipp;
        fbp = longint'(fb) + 2;
        ipp = longint'(ip) + 2;
        return (CRYSTAL_HZ * fbp) / (ipp * out_div_of(op));
    endfunction

    function automatic clk_result_t predict_clock(input logic kind, input logic audio,
                                                  input logic [RATE_W-1:0] rate,
                                                  input logic [CODE_W-1:0] code);
        clk_result_t     r;
        longint unsigned pll;
        longint unsigned rt;
        longint unsigned d;
        longint unsigned q;
        r   = '0;
        pll = pll_hz_of(fb_q, ip_q, op_q);
        rt  = longint'(rate);
        r.pll = pll[PLL_W-1:0];
        if (!audio) begin
            r.status = STATUS_NOT_AUDIO;
        end else if (kind == KIND_DIV_FROM_RATE) begin
            if (rt == 0) begin
                r.status = STATUS_ZERO_RATE;
            end else begin
                // round to nearest, then clamp the divider to 1..128
                d = (pll / AUD_SCALE + rt / 2) / rt;
                if (d == 0) d = 1;
                if (d > DIV_TOP) d = DIV_TOP;
                d = d - 1;
                r.divo   = d[DIVO_W-1:0];
                r.status = STATUS_OK;
            end
        end else begin
            q = pll / (AUD_SCALE * (longint'(code) + 1));
            r.arate  = q[ARATE_W-1:0];
            r.status = STATUS_OK;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(input logic kind, input logic audio,
                            input logic [RATE_W-1:0] rate, input logic [CODE_W-1:0] code,
                            input logic typed, input clk_result_t res);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'd0, code, rate};
        s_axis_tuser  = {audio, kind};
        cur_typed     = typed;
        cur_res       = res;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic send_random_req();
        logic              kind;
        logic              audio;
        logic [RATE_W-1:0] rate;
        logic [CODE_W-1:0] code;
        int unsigned       aud;
        int unsigned       pick;
        aud   = int'(pll_hz_of(fb_q, ip_q, op_q) / AUD_SCALE);
        kind  = 1'($urandom_range(0, 1));
        audio = ($urandom_range(0, 99) < 92);
        code  = CODE_W'($urandom);
        pick  = $urandom_range(0, 99);
        if (pick < 5)
            rate = '0;
        else if (pick < 50)
            rate = RATE_W'($urandom_range(1, aud + aud / 2));
        else if (pick < 65)
            // around the upper clamp of the divider
            rate = RATE_W'($urandom_range(aud / 140 + 1, aud / 120 + 1));
        else
            rate = RATE_W'($urandom);
        send_req(kind, audio, rate, code, 1'b0, NO_RES);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // sink stalls
    always @(negedge aclk) begin
        if (!aresetn)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge aclk) begin : watch
        clk_result_t got;
        clk_result_t want;
        if (!aresetn) begin
            fb_q <= '0;
            ip_q <= '0;
            op_q <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_FEEDBACK:   fb_q <= cfg_wdata[FB_W-1:0];
                    CFG_INPUT_DIV:  ip_q <= cfg_wdata[IP_W-1:0];
                    CFG_OUTPUT_DIV: op_q <= cfg_wdata[OP_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (cur_typed)
                    pending_results.push_back(cur_res);
                else
                    pending_results.push_back(predict_clock(s_axis_tuser[0], s_axis_tuser[1],
                        s_axis_tdata[RATE_W-1:0], s_axis_tdata[RATE_W +: CODE_W]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.pll    = m_axis_tdata[PLL_W-1:0];
                got.divo   = m_axis_tdata[DIVO_LSB +: DIVO_W];
                got.arate  = m_axis_tdata[ARATE_LSB +: ARATE_W];
                got.status = m_axis_tuser[STATUS_W-1:0];
                if (pending_results.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    if (got.pll !== want.pll)
                        report_mismatch($sformatf("pll_hz got %0d want %0d",
                                                  got.pll, want.pll));
                    if (got.divo !== want.divo)
                        report_mismatch($sformatf("divider_out got %0d want %0d",
                                                  got.divo, want.divo));
                    if (got.arate !== want.arate)
                        report_mismatch($sformatf("audio_rate_hz got %0d want %0d",
                                                  got.arate, want.arate));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  got.status, want.status));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stim
        logic [CFG_DATA_W-1:0] fb_w;
        logic [CFG_DATA_W-1:0] ip_w;
        logic [CFG_DATA_W-1:0] op_w;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_ROWS; i++)
            send_req(DIR_ROWS[i].kind, DIR_ROWS[i].audio, DIR_ROWS[i].rate,
                     DIR_ROWS[i].code, DIR_ROWS[i].typed, DIR_ROWS[i].res);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // extremes first, then random settings with junk in the upper bits
            case (ph)
                0: begin fb_w = 7'd127; ip_w = 7'd0;  op_w = 7'd0; end
                1: begin fb_w = 7'd0;   ip_w = 7'd31; op_w = 7'd3; end
                2: begin fb_w = 7'h7F;  ip_w = 7'h7F; op_w = 7'h7F; end
                3: begin fb_w = 7'd0;   ip_w = 7'd0;  op_w = 7'd2; end
                default: begin
                    fb_w = CFG_DATA_W'($urandom);
                    ip_w = CFG_DATA_W'($urandom);
                    op_w = CFG_DATA_W'($urandom);
                end
            endcase
            write_reg(CFG_FEEDBACK, fb_w);
            write_reg(CFG_INPUT_DIV, ip_w);
            write_reg(CFG_OUTPUT_DIV, op_w);
            write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
            @(negedge aclk);
            idle_on = (ph != QUIET_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_req();
            drain();
            idle_on = 1'b1;
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
